### rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, codes and note tables for the alarm and quarter-chime
// sequencer.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned DurW    = 5;
  localparam int unsigned MsgW    = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 6;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  localparam logic [PeriodW-1:0] SilentPeriod = 16'd1000;
  localparam logic [PeriodW-1:0] StrikePeriod = 16'd24242;  // 165 Hz

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALARM_HOUR   = 2'd0,
    CFG_ALARM_MINUTE = 2'd1,
    CFG_ALARM_SECOND = 2'd2
  } cfg_idx_t;

  typedef enum logic [MsgW-1:0] {
    MSG_NONE       = 3'd0,
    MSG_ALARM      = 3'd1,
    MSG_TOP        = 3'd2,
    MSG_QUARTER    = 3'd3,
    MSG_HALF       = 3'd4,
    MSG_QUARTER_TO = 3'd5
  } msg_t;

  typedef enum logic [2:0] {
    CH_NONE,
    CH_TOP,
    CH_QUARTER,
    CH_HALF,
    CH_QUARTER_TO
  } chime_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALARM,
    ST_PHRASE,
    ST_STRIKE
  } seq_state_t;

  typedef struct packed {
    logic       alarm;
    chime_t     chime;
    logic [3:0] strikes;
  } job_t;

  function automatic logic [PeriodW-1:0] melody_period(input logic [2:0] idx);
    logic [PeriodW-1:0] p;
    case (idx)
      3'd0:    p = 16'd15325;  // 261 Hz
      3'd1:    p = 16'd10204;  // 392 Hz
      3'd2:    p = 16'd12158;  // 329 Hz
      3'd3:    p = 16'd9090;   // 440 Hz
      3'd4:    p = 16'd8097;   // 494 Hz
      3'd5:    p = 16'd9090;
      3'd6:    p = 16'd10204;
      3'd7:    p = 16'd12158;
      default: p = SilentPeriod;
    endcase
    return p;
  endfunction

  // note periods: 415 Hz 9638, 370 Hz 10810, 330 Hz 12121, 247 Hz 16194
  function automatic logic [PeriodW-1:0] phrase_period(input logic [2:0] phrase,
                                                        input logic [1:0] note);
    logic [PeriodW-1:0] p;
    case ({phrase, note})
      5'b000_00: p = 16'd9638;
      5'b000_01: p = 16'd10810;
      5'b000_10: p = 16'd12121;
      5'b000_11: p = 16'd16194;
      5'b001_00: p = 16'd12121;
      5'b001_01: p = 16'd9638;
      5'b001_10: p = 16'd10810;
      5'b001_11: p = 16'd16194;
      5'b010_00: p = 16'd12121;
      5'b010_01: p = 16'd10810;
      5'b010_10: p = 16'd9638;
      5'b010_11: p = 16'd12121;
      5'b011_00: p = 16'd9638;
      5'b011_01: p = 16'd12121;
      5'b011_10: p = 16'd10810;
      5'b011_11: p = 16'd16194;
      5'b100_00: p = 16'd16194;
      5'b100_01: p = 16'd10810;
      5'b100_10: p = 16'd9638;
      5'b100_11: p = 16'd12121;
      default:   p = SilentPeriod;
    endcase
    return p;
  endfunction

  // phrase played at position pos of a chime
  function automatic logic [2:0] phrase_index(input chime_t kind, input logic [1:0] pos);
    logic [2:0] r;
    case (kind)
      CH_TOP:        r = {1'b0, pos} + 3'd1;
      CH_QUARTER:    r = 3'd0;
      CH_HALF:       r = {1'b0, pos} + 3'd1;
      CH_QUARTER_TO: r = (pos == 2'd2) ? 3'd0 : {1'b0, pos} + 3'd3;
      default:       r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] phrase_last_pos(input chime_t kind);
    logic [1:0] r;
    case (kind)
      CH_TOP:        r = 2'd3;
      CH_QUARTER:    r = 2'd0;
      CH_HALF:       r = 2'd1;
      CH_QUARTER_TO: r = 2'd2;
      default:       r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic msg_t chime_msg(input chime_t kind);
    msg_t m;
    case (kind)
      CH_TOP:        m = MSG_TOP;
      CH_QUARTER:    m = MSG_QUARTER;
      CH_HALF:       m = MSG_HALF;
      CH_QUARTER_TO: m = MSG_QUARTER_TO;
      default:       m = MSG_NONE;
    endcase
    return m;
  endfunction

endpackage

### rtl/ccs_front.sv
// ----------------------------------------------------------------------------
// ccs_front
// Takes clock samples, checks alarm and chime marks, keeps the one-shot
// flags and pushes a job for each sample that fires anything.
// ----------------------------------------------------------------------------
module ccs_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ccs_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [ccs_pkg::CfgW-1:0]            cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ccs_pkg::InDataW-1:0]         s_tdata,
  input  logic                                q_full,
  output logic                                q_push,
  output ccs_pkg::job_t                       q_job
);
  import ccs_pkg::*;

  logic [HourW-1:0]   alarm_hour;
  logic [MinuteW-1:0] alarm_minute;
  logic [SecondW-1:0] alarm_second;
  logic               alarm_played;
  logic               chime_played;

  logic [HourW-1:0]   hour;
  logic [MinuteW-1:0] minute;
  logic [SecondW-1:0] second;
  logic               accept;
  logic               alarm_fire;
  chime_t             chime;
  logic               quarter_mark;
  logic [HourW-1:0]   hour_mod;
  logic [3:0]         strikes;

  assign hour   = s_tdata[HourW-1:0];
  assign minute = s_tdata[HourW+MinuteW-1:HourW];
  assign second = s_tdata[HourW+MinuteW+SecondW-1:HourW+MinuteW];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign alarm_fire = !alarm_played && hour == alarm_hour && minute == alarm_minute
                      && second >= alarm_second;
  assign quarter_mark = minute inside {6'd0, 6'd15, 6'd30, 6'd45, 6'd60};

  always_comb begin
    chime = CH_NONE;
    if (!chime_played) begin
      case (minute)
        6'd0:    chime = CH_TOP;
        6'd15:   chime = CH_QUARTER;
        6'd30:   chime = CH_HALF;
        6'd45:   chime = (second <= 6'd3) ? CH_QUARTER_TO : CH_NONE;
        default: chime = CH_NONE;
      endcase
    end
  end

  // hour mod 12, twelve when zero
  always_comb begin
    if (hour >= 5'd24) begin
      hour_mod = hour - 5'd24;
    end else if (hour >= 5'd12) begin
      hour_mod = hour - 5'd12;
    end else begin
      hour_mod = hour;
    end
    strikes = (hour_mod == 5'd0) ? 4'd12 : hour_mod[3:0];
  end

  assign q_push        = accept && (alarm_fire || chime != CH_NONE);
  assign q_job.alarm   = alarm_fire;
  assign q_job.chime   = chime;
  assign q_job.strikes = strikes;

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_hour   <= '0;
      alarm_minute <= '0;
      alarm_second <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALARM_HOUR:   alarm_hour   <= cfg_data[HourW-1:0];
        CFG_ALARM_MINUTE: alarm_minute <= cfg_data[MinuteW-1:0];
        CFG_ALARM_SECOND: alarm_second <= cfg_data[SecondW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_played <= 1'b0;
      chime_played <= 1'b0;
    end else if (accept) begin
      if (alarm_fire) begin
        alarm_played <= 1'b1;
      end else if (minute != alarm_minute) begin
        alarm_played <= 1'b0;
      end
      if (chime != CH_NONE) begin
        chime_played <= 1'b1;
      end else if (chime_played && !quarter_mark) begin
        chime_played <= 1'b0;
      end
    end
  end

endmodule

### rtl/ccs_queue.sv
// ----------------------------------------------------------------------------
// ccs_queue
// Short job queue between the sample front end and the tone sequencer.
// ----------------------------------------------------------------------------
module ccs_queue #(
  parameter int unsigned DEPTH = ccs_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ccs_pkg::job_t  push_job,
  input  logic           pop,
  output ccs_pkg::job_t  head_job,
  output logic           full,
  output logic           empty
);
  import ccs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("job pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job popped from empty queue");

endmodule

### rtl/ccs_back.sv
// ----------------------------------------------------------------------------
// ccs_back
// Tone sequencer: pops a job and emits its alarm melody, chime phrases and
// hour strikes, one command per cycle unless stalled, through an output register.
// ----------------------------------------------------------------------------
module ccs_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  ccs_pkg::job_t                   q_head,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ccs_pkg::OutDataW-1:0]    m_tdata,
  output logic                            m_tlast
);
  import ccs_pkg::*;

  seq_state_t state, state_next;
  job_t       job;
  logic [3:0] note;
  logic [1:0] pos;
  logic [3:0] scnt;
  logic       sub;

  logic               emit;
  logic [PeriodW-1:0] cmd_period;
  logic               cmd_on;
  logic [DurW-1:0]    cmd_dur;
  msg_t               cmd_msg;
  logic               cmd_last;
  logic               last_phrase;
  logic [2:0]         pidx;

  assign emit        = state != ST_IDLE && (!m_tvalid || m_tready);
  assign q_pop       = state == ST_IDLE && !q_empty;
  assign last_phrase = pos == phrase_last_pos(job.chime);
  assign pidx        = phrase_index(job.chime, pos);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = q_head.alarm ? ST_ALARM : ST_PHRASE;
        end
      end
      ST_ALARM: begin
        if (emit && note == 4'd8) begin
          state_next = (job.chime == CH_NONE) ? ST_IDLE : ST_PHRASE;
        end
      end
      ST_PHRASE: begin
        if (emit && note == 4'd4 && last_phrase) begin
          state_next = (job.chime == CH_TOP) ? ST_STRIKE : ST_IDLE;
        end
      end
      ST_STRIKE: begin
        if (emit && cmd_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command for the current step
  always_comb begin
    cmd_period = SilentPeriod;
    cmd_on     = 1'b0;
    cmd_dur    = '0;
    cmd_msg    = MSG_NONE;
    cmd_last   = 1'b0;
    case (state)
      ST_ALARM: begin
        cmd_msg = MSG_ALARM;
        if (note == 4'd8) begin
          cmd_last = job.chime == CH_NONE;
        end else begin
          cmd_period = melody_period(note[2:0]);
          cmd_on     = 1'b1;
          cmd_dur    = 5'd4;
        end
      end
      ST_PHRASE: begin
        cmd_msg = chime_msg(job.chime);
        if (note == 4'd4) begin
          cmd_dur  = (last_phrase && job.chime == CH_TOP) ? 5'd8 : 5'd0;
          cmd_last = last_phrase && job.chime != CH_TOP;
        end else begin
          cmd_period = phrase_period(pidx, note[1:0]);
          cmd_on     = 1'b1;
          cmd_dur    = (note == 4'd3) ? 5'd8 : 5'd4;
        end
      end
      ST_STRIKE: begin
        cmd_msg = MSG_TOP;
        if (sub) begin
          cmd_dur  = 5'd1;
          cmd_last = scnt == job.strikes - 4'd1;
        end else begin
          cmd_period = StrikePeriod;
          cmd_on     = 1'b1;
          cmd_dur    = 5'd16;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job  <= q_head;
      note <= '0;
      pos  <= '0;
      scnt <= '0;
      sub  <= 1'b0;
    end else if (emit) begin
      case (state)
        ST_ALARM: note <= (note == 4'd8) ? 4'd0 : note + 4'd1;
        ST_PHRASE: begin
          if (note == 4'd4) begin
            note <= '0;
            pos  <= pos + 2'd1;
          end else begin
            note <= note + 4'd1;
          end
        end
        ST_STRIKE: begin
          sub <= !sub;
          if (sub) begin
            scnt <= scnt + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {7'd0, cmd_msg, cmd_dur, cmd_on, cmd_period};
      m_tlast <= cmd_last;
    end
  end

  a_strike_top: assert property (@(posedge clk) disable iff (rst)
    state == ST_STRIKE |-> job.chime == CH_TOP)
    else $error("hour strikes outside top-of-hour chime");
  a_alarm_job: assert property (@(posedge clk) disable iff (rst)
    state == ST_ALARM |-> job.alarm)
    else $error("alarm melody without alarm request");

endmodule

### rtl/clock_alarm_chime_sequencer_top.sv
// ----------------------------------------------------------------------------
// clock_alarm_chime_sequencer_top
// Alarm and Westminster quarter chime sequencer for a real-time clock.
// ----------------------------------------------------------------------------
// Input stream s_*: one clock sample per request. Output stream m_*: tone
// commands, m_tlast on the final command of a sample's run. Samples that
// fire nothing produce no output. Alarm commands precede chime commands.
// The front end pushes a job for each accepted sample that fires anything
// into the job queue (two entries by default); the back end pops it while
// idle and emits its run of N commands (5 to 53) through an output
// register. Command rate is set by the back-end sequencer: one command per
// cycle within a run while m_tready does not stall the output.
// s_tready drops only while the job queue is full; a stall on m_tready
// holds the output register and the sequencer, and the queue fills behind.
// Config writes (cfg_we/cfg_index/cfg_data) take effect at once; write only
// while idle. Reset clears alarm registers, one-shot flags, queue and
// output valid.
// ----------------------------------------------------------------------------
module clock_alarm_chime_sequencer_top #(
  parameter int unsigned QUEUE_DEPTH = ccs_pkg::QueueDepth
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ccs_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [ccs_pkg::CfgW-1:0]         cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ccs_pkg::InDataW-1:0]      s_tdata,   // hour, minute, second
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ccs_pkg::OutDataW-1:0]     m_tdata,   // tone_period, tone_on, duration, message
  output logic                             m_tlast
);
  import ccs_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  job_t push_job;
  job_t head_job;

  ccs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  ccs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  ccs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (head_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
